// ===== design/srv_pkg.sv =====
// Package for the Snell refraction pipeline: widths, number-format constants,
// rounding and saturation helpers, and the sideband and result types.
// No dependencies; every other design file imports it.
`default_nettype none

package srv_pkg;

    // Number format
    localparam int FRAC_BITS = 16;
    localparam int DIR_W     = 32;
    localparam int NRM_W     = 18;
    localparam int K_W       = 18;
    localparam int OUT_W     = 32;

    // Square-root unit: one result bit per stage
    localparam int RAD_W     = 64;
    localparam int SQ_STAGES = RAD_W / 2;
    localparam int ROOT_W    = RAD_W / 2;

    // Divider: one quotient bit per stage; the quotient never exceeds 1.0
    localparam int DIV_QW    = FRAC_BITS + 1;
    localparam int DIV_NW    = DIR_W + FRAC_BITS;

    // Intermediate widths, sized to the largest magnitude each can reach
    localparam int UV_W  = FRAC_BITS + 2;
    localparam int P_W   = UV_W + NRM_W;
    localparam int KK_W  = 2 * K_W;
    localparam int DT_W  = FRAC_BITS + 4;
    localparam int K2_W  = 2 * K_W - FRAC_BITS + 1;
    localparam int DD_W  = 2 * DT_W;
    localparam int ND_W  = NRM_W + DT_W;
    localparam int OM_W  = FRAC_BITS + 7;
    localparam int A_W   = FRAC_BITS + 5;
    localparam int KM_W  = K2_W + 1 + OM_W;
    localparam int KA_W  = K_W + 1 + A_W;
    localparam int KAR_W = KA_W - FRAC_BITS + 1;
    localparam int S_W   = FRAC_BITS + 6;
    localparam int NS_W  = NRM_W + S_W + 1;

    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic        [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

    // Sideband carried alongside the first square root
    typedef struct packed {
        logic [2:0][DIR_W-1:0] mag;
        logic [2:0]            neg;
        logic [2:0][NRM_W-1:0] nrm;
        logic [K_W-1:0]        k;
    } t_sb_len;

    // Sideband carried alongside the dividers
    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][NRM_W-1:0] nrm;
        logic [K_W-1:0]        k;
        logic                  zero;
    } t_sb_div;

    // Sideband carried alongside the second square root
    typedef struct packed {
        logic [2:0][KAR_W-1:0] kar;
        logic [2:0][NRM_W-1:0] nrm;
        logic                  pos;
    } t_sb_disc;

    typedef struct packed {
        logic [OUT_W-1:0] refr_x;
        logic [OUT_W-1:0] refr_y;
        logic [OUT_W-1:0] refr_z;
        logic             did_refract;
    } t_res;

    // Right shift by FRAC_BITS, rounding half away from zero.
    function automatic logic signed [63:0] rs(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + HALF) >> FRAC_BITS;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [63:0] x);
        logic [OUT_W-1:0] r;
        if (x > OUT_MAX) begin
            r = OUT_MAX[OUT_W-1:0];
        end else if (x < OUT_MIN) begin
            r = OUT_MIN[OUT_W-1:0];
        end else begin
            r = x[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/srv_if.sv =====
// Valid/ready channel interfaces for the refraction pipeline requests and results.
// Depends on srv_pkg for the field widths.
`default_nettype none

interface srv_in_if;
    import srv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic        [K_W-1:0]   index_ratio;

    modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                    index_ratio, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                    index_ratio, output ready);
endinterface

interface srv_out_if;
    import srv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] refr_x;
    logic signed [OUT_W-1:0] refr_y;
    logic signed [OUT_W-1:0] refr_z;
    logic                    did_refract;

    modport source (output valid, refr_x, refr_y, refr_z, did_refract, input ready);
    modport sink   (input valid, refr_x, refr_y, refr_z, did_refract, output ready);
endinterface

`default_nettype wire

// ===== design/srv_isqrt.sv =====
// Pipelined integer square root, one result bit resolved per stage.
// Depends on srv_pkg.
`default_nettype none

module srv_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [srv_pkg::RAD_W-1:0]  i_rad,
    output logic                       o_valid,
    output logic [srv_pkg::ROOT_W-1:0] o_root
);
    import srv_pkg::*;

    logic             r_v   [SQ_STAGES];
    logic [RAD_W-1:0] r_num [SQ_STAGES];
    logic [RAD_W-1:0] r_res [SQ_STAGES];
    logic [RAD_W-1:0] n_num [SQ_STAGES];
    logic [RAD_W-1:0] n_res [SQ_STAGES];

    always_comb begin
        logic [RAD_W-1:0] num_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] bit_w;
        logic [RAD_W-1:0] trial;
        for (int i = 0; i < SQ_STAGES; i++) begin
            if (i == 0) begin
                num_in = i_rad;
                res_in = '0;
            end else begin
                num_in = r_num[i-1];
                res_in = r_res[i-1];
            end
            bit_w = RAD_W'(1) << (RAD_W - 2 - 2 * i);
            trial = res_in + bit_w;
            if (num_in >= trial) begin
                n_num[i] = num_in - trial;
                n_res[i] = (res_in >> 1) + bit_w;
            end else begin
                n_num[i] = num_in;
                n_res[i] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SQ_STAGES; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < SQ_STAGES; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < SQ_STAGES; i++) begin
                r_num[i] <= n_num[i];
                r_res[i] <= n_res[i];
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_res[SQ_STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== design/srv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for quotients below
// twice 1.0 in the fixed-point format. Depends on srv_pkg.
`default_nettype none

module srv_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [srv_pkg::DIV_NW-1:0] i_num,
    input  logic [srv_pkg::DIR_W-1:0]  i_den,
    output logic                       o_valid,
    output logic [srv_pkg::DIV_QW-1:0] o_quot
);
    import srv_pkg::*;

    logic              r_v    [DIV_QW];
    logic [DIV_NW-1:0] r_rem  [DIV_QW];
    logic [DIR_W-1:0]  r_den  [DIV_QW];
    logic [DIV_QW-1:0] r_quot [DIV_QW];
    logic [DIV_NW-1:0] n_rem  [DIV_QW];
    logic [DIV_QW-1:0] n_quot [DIV_QW];

    always_comb begin
        logic [DIV_NW-1:0] rem_in;
        logic [DIR_W-1:0]  den_in;
        logic [DIV_QW-1:0] quot_in;
        logic [DIV_NW-1:0] trial;
        for (int i = 0; i < DIV_QW; i++) begin
            if (i == 0) begin
                rem_in  = i_num;
                den_in  = i_den;
                quot_in = '0;
            end else begin
                rem_in  = r_rem[i-1];
                den_in  = r_den[i-1];
                quot_in = r_quot[i-1];
            end
            trial = DIV_NW'(den_in) << (DIV_QW - 1 - i);
            if (rem_in >= trial) begin
                n_rem[i]  = rem_in - trial;
                n_quot[i] = quot_in | (DIV_QW'(1) << (DIV_QW - 1 - i));
            end else begin
                n_rem[i]  = rem_in;
                n_quot[i] = quot_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_QW; i++) r_v[i] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < DIV_QW; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            for (int i = 1; i < DIV_QW; i++) r_den[i] <= r_den[i-1];
            for (int i = 0; i < DIV_QW; i++) begin
                r_rem[i]  <= n_rem[i];
                r_quot[i] <= n_quot[i];
            end
        end
    end

    assign o_valid = r_v[DIV_QW-1];
    assign o_quot  = r_quot[DIV_QW-1];

endmodule

`default_nettype wire

// ===== design/snell_refraction_vector.sv =====
// Snell refraction pipeline, top level. Depends on srv_pkg, srv_if, srv_isqrt, srv_div.
// Throughput: one request per cycle while the skid register is empty; the figure is set
// by the two 32-stage square roots and the 17-stage dividers, all fully pipelined.
// Reset (synchronous, active low) clears every valid bit; payload registers are not reset.
`default_nettype none

module snell_refraction_vector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srv_in_if.sink    i_in,
    srv_out_if.source o_out
);
    import srv_pkg::*;

    // The whole pipeline advances together. It only halts when the skid register
    // already holds a result, so o_out.ready never reaches the input combinationally.
    logic w_en;

    logic r_skid_v;
    logic r_out_v;
    t_res r_skid;
    t_res r_out;

    assign w_en       = ~r_skid_v;
    assign i_in.ready = w_en;

    // Stage 1: magnitudes and signs of the direction, inputs registered.
    logic    r1_v;
    t_sb_len r1_sb;
    logic signed [DIR_W-1:0] w_dir [3];

    assign w_dir[0] = i_in.dir_x;
    assign w_dir[1] = i_in.dir_y;
    assign w_dir[2] = i_in.dir_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_sb.mag[i] <= w_dir[i][DIR_W-1] ? DIR_W'(-w_dir[i]) : DIR_W'(w_dir[i]);
                r1_sb.neg[i] <= w_dir[i][DIR_W-1];
            end
            r1_sb.nrm[0] <= i_in.norm_x;
            r1_sb.nrm[1] <= i_in.norm_y;
            r1_sb.nrm[2] <= i_in.norm_z;
            r1_sb.k      <= i_in.index_ratio;
        end
    end

    // Stage 2: squares of the magnitudes, one multiplier per lane.
    logic             r2_v;
    t_sb_len          r2_sb;
    logic [RAD_W-1:0] r2_sq [3];

    // Stage 3: sum of squares; it always fits in 64 bits.
    logic             r3_v;
    t_sb_len          r3_sb;
    logic [RAD_W-1:0] r3_sq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= RAD_W'(r1_sb.mag[i]) * RAD_W'(r1_sb.mag[i]);
            end
            r2_sb <= r1_sb;
            r3_sq <= r2_sq[0] + r2_sq[1] + r2_sq[2];
            r3_sb <= r2_sb;
        end
    end

    // Length of the direction, with its sideband delayed alongside.
    logic              w_len_v;
    logic [ROOT_W-1:0] w_len;
    t_sb_len           r_sba [SQ_STAGES];

    srv_isqrt u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_rad   (r3_sq),
        .o_valid (w_len_v),
        .o_root  (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sba[0] <= r3_sb;
            for (int i = 1; i < SQ_STAGES; i++) r_sba[i] <= r_sba[i-1];
        end
    end

    // Stage 4: rounded dividends for normalising each component.
    logic              r4_v;
    logic [DIV_NW-1:0] r4_num [3];
    logic [DIR_W-1:0]  r4_len;
    t_sb_div           r4_sb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= (DIV_NW'(r_sba[SQ_STAGES-1].mag[i]) << FRAC_BITS)
                             + DIV_NW'(w_len >> 1);
            end
            r4_len       <= w_len[DIR_W-1:0];
            r4_sb.neg    <= r_sba[SQ_STAGES-1].neg;
            r4_sb.nrm    <= r_sba[SQ_STAGES-1].nrm;
            r4_sb.k      <= r_sba[SQ_STAGES-1].k;
            r4_sb.zero   <= (w_len == '0);
        end
    end

    // Three dividers produce the magnitudes of the unit vector.
    logic [2:0]        w_div_v;
    logic [DIV_QW-1:0] w_quot [3];
    t_sb_div           r_sbb [DIV_QW];

    for (genvar g = 0; g < 3; g++) begin : g_div
        srv_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r4_v),
            .i_num   (r4_num[g]),
            .i_den   (r4_len),
            .o_valid (w_div_v[g]),
            .o_quot  (w_quot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sbb[0] <= r4_sb;
            for (int i = 1; i < DIV_QW; i++) r_sbb[i] <= r_sbb[i-1];
        end
    end

    // Stage 5: signed unit vector.
    logic                   r5_v;
    logic signed [UV_W-1:0] r5_uv [3];
    t_sb_div                r5_sb;

    // Stage 6: products uv*n and k*k.
    logic                   r6_v;
    logic signed [P_W-1:0]  r6_p  [3];
    logic signed [UV_W-1:0] r6_uv [3];
    logic [KK_W-1:0]        r6_kk;
    t_sb_div                r6_sb;

    // Stage 7: dot product dt and k squared, both rescaled.
    logic                   r7_v;
    logic signed [DT_W-1:0] r7_dt;
    logic [K2_W-1:0]        r7_k2;
    logic signed [UV_W-1:0] r7_uv [3];
    t_sb_div                r7_sb;

    // Stage 8: dt squared and n*dt.
    logic                   r8_v;
    logic signed [DD_W-1:0] r8_dd;
    logic signed [ND_W-1:0] r8_nd [3];
    logic [K2_W-1:0]        r8_k2;
    logic signed [UV_W-1:0] r8_uv [3];
    t_sb_div                r8_sb;

    // Stage 9: 1 - dt^2 and the tangential part uv - n*dt.
    logic                   r9_v;
    logic signed [OM_W-1:0] r9_om;
    logic signed [A_W-1:0]  r9_a [3];
    logic [K2_W-1:0]        r9_k2;
    t_sb_div                r9_sb;

    // Stage 10: k^2 (1 - dt^2) and k times the tangential part.
    logic                   r10_v;
    logic signed [KM_W-1:0] r10_km;
    logic signed [KA_W-1:0] r10_ka [3];
    t_sb_div                r10_sb;

    // Stage 11: discriminant; a non-positive one or a zero-length direction
    // feeds zero to the root and clears the refracted flag.
    logic             r11_v;
    logic [RAD_W-1:0] r11_rad;
    t_sb_disc         r11_sb;

    logic [UV_W-1:0] w_qx [3];
    logic signed [63:0] w_disc;

    always_comb begin
        for (int i = 0; i < 3; i++) w_qx[i] = UV_W'(w_quot[i]);
        w_disc = ONE - rs(64'(r10_km));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_uv[i] <= r_sbb[DIV_QW-1].neg[i] ? -$signed(w_qx[i]) : $signed(w_qx[i]);
            end
            r5_sb <= r_sbb[DIV_QW-1];

            for (int i = 0; i < 3; i++) begin
                r6_p[i] <= r5_uv[i] * $signed(r5_sb.nrm[i]);
            end
            r6_uv <= r5_uv;
            r6_kk <= KK_W'(r5_sb.k) * KK_W'(r5_sb.k);
            r6_sb <= r5_sb;

            r7_dt <= DT_W'(rs(64'(r6_p[0]) + 64'(r6_p[1]) + 64'(r6_p[2])));
            r7_k2 <= K2_W'(rs($signed(64'(r6_kk))));
            r7_uv <= r6_uv;
            r7_sb <= r6_sb;

            r8_dd <= r7_dt * r7_dt;
            for (int i = 0; i < 3; i++) begin
                r8_nd[i] <= $signed(r7_sb.nrm[i]) * r7_dt;
            end
            r8_k2 <= r7_k2;
            r8_uv <= r7_uv;
            r8_sb <= r7_sb;

            r9_om <= OM_W'(ONE - rs(64'(r8_dd)));
            for (int i = 0; i < 3; i++) begin
                r9_a[i] <= A_W'(64'(r8_uv[i]) - rs(64'(r8_nd[i])));
            end
            r9_k2 <= r8_k2;
            r9_sb <= r8_sb;

            r10_km <= $signed({1'b0, r9_k2}) * r9_om;
            for (int i = 0; i < 3; i++) begin
                r10_ka[i] <= $signed({1'b0, r9_sb.k}) * r9_a[i];
            end
            r10_sb <= r9_sb;

            if ((w_disc > 64'sd0) && !r10_sb.zero) begin
                r11_rad    <= RAD_W'(w_disc <<< FRAC_BITS);
                r11_sb.pos <= 1'b1;
            end else begin
                r11_rad    <= '0;
                r11_sb.pos <= 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                r11_sb.kar[i] <= KAR_W'(rs(64'(r10_ka[i])));
            end
            r11_sb.nrm <= r10_sb.nrm;
        end
    end

    // Square root of the discriminant, with its sideband delayed alongside.
    logic              w_s_v;
    logic [ROOT_W-1:0] w_s;
    t_sb_disc          r_sbc [SQ_STAGES];

    srv_isqrt u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r11_v),
        .i_rad   (r11_rad),
        .o_valid (w_s_v),
        .o_root  (w_s)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sbc[0] <= r11_sb;
            for (int i = 1; i < SQ_STAGES; i++) r_sbc[i] <= r_sbc[i-1];
        end
    end

    // Stage 12: n*s. Stage 13: final combination, saturation and masking.
    logic                    r12_v;
    logic signed [NS_W-1:0]  r12_ns [3];
    logic signed [KAR_W-1:0] r12_kar [3];
    logic                    r12_pos;
    logic                    r13_v;
    t_res                    r13_res;
    logic signed [63:0]      w_r [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_r[i] = 64'(r12_kar[i]) - rs(64'(r12_ns[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r12_ns[i]  <= $signed(r_sbc[SQ_STAGES-1].nrm[i])
                              * $signed({1'b0, w_s[S_W-1:0]});
                r12_kar[i] <= $signed(r_sbc[SQ_STAGES-1].kar[i]);
            end
            r12_pos <= r_sbc[SQ_STAGES-1].pos;

            r13_res.refr_x      <= r12_pos ? sat_out(w_r[0]) : '0;
            r13_res.refr_y      <= r12_pos ? sat_out(w_r[1]) : '0;
            r13_res.refr_z      <= r12_pos ? sat_out(w_r[2]) : '0;
            r13_res.did_refract <= r12_pos;
        end
    end

    // Valid bits of the stages held in this module.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
        end else if (w_en) begin
            r1_v  <= i_in.valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= w_len_v;
            r5_v  <= &w_div_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
            r11_v <= r10_v;
            r12_v <= w_s_v;
            r13_v <= r12_v;
        end
    end

    // Output register with a skid register behind it. A result that arrives while
    // the output is stalled parks in the skid register, which then halts the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (o_out.ready || !r_out_v) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r13_v;
            end
        end else if (r13_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out.ready || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : r13_res;
        end else if (!r_skid_v) begin
            r_skid <= r13_res;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.refr_x      = r_out.refr_x;
    assign o_out.refr_y      = r_out.refr_y;
    assign o_out.refr_z      = r_out.refr_z;
    assign o_out.did_refract = r_out.did_refract;

endmodule

`default_nettype wire
